// ===== hw/rtl/spt_pkg.sv =====
// ---------------------------------------------------------------------------
// spt_pkg: shared types and constants of the spindle rpm tracker
// Phase codes, configuration indexes, command and status words.
// ---------------------------------------------------------------------------
`default_nettype none

package spt_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 16;
  localparam int unsigned PERIOD_WIDTH_DEF = 16;

  localparam int unsigned PORT_PERIOD_W = 16;
  localparam int unsigned AVG_W         = 16;
  localparam int unsigned RPM_W         = 15;
  localparam int unsigned CFG_W         = 16;
  localparam int unsigned IDLE_W        = 16;
  localparam int unsigned RATE_NUM_W    = 22;  // 65535 * 60 < 2**22
  localparam int unsigned SEC_PER_MIN   = 60;

  localparam logic [CFG_W-1:0]  RATE_RESET    = 16'd20000;
  localparam logic [CFG_W-1:0]  TIMEOUT_RESET = 16'd250;
  localparam logic [IDLE_W-1:0] IDLE_MAX      = '1;
  localparam logic [RPM_W-1:0]  RPM_MAX       = '1;

  typedef enum logic {
    CFG_PULSE_RATE = 1'b0,
    CFG_TIMEOUT    = 1'b1
  } spt_cfg_idx_e;

  typedef enum logic [1:0] {
    PH_ZERO     = 2'd0,
    PH_STARTING = 2'd1,
    PH_STEADY   = 2'd2,
    PH_SLOWING  = 2'd3
  } spt_phase_e;

  typedef struct packed {
    logic             we;
    spt_cfg_idx_e     index;
    logic [CFG_W-1:0] data;
  } spt_cfg_t;

  typedef struct packed {
    logic       capture;
    logic       fill_clr;
    logic       fill_wr;
    logic       rd_old;
    logic       upd;
    logic       set_latest;
    logic       div_start;
    logic       avg_load;
    logic       rpm_load;
    logic       rpm_clr;
    logic       out_clr;
    logic       out_load;
    spt_phase_e phase;
  } spt_cmd_t;

  typedef struct packed {
    logic period_zero;
    logic fill_last;
    logic div_done;
    logic avg_zero;
  } spt_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spindle_rpm_tracker_top.sv =====
// ---------------------------------------------------------------------------
// spindle_rpm_tracker_top: averaged spindle period and rpm meter
// Zero, slowing and no-event words go straight to the result word stage. A
// steady event word first passes the window update, the average and, unless
// the average is zero, the RATE_NUM_W (22) bit bit-serial rpm divider; a first
// fill sweeps all WINDOW_DEPTH window slots in place of the update. One word in
// flight at a time: the next word is accepted only after the result loads.
// Reset: asynchronous, clears phase, counters, sums and out_valid; no clear pass.
// ---------------------------------------------------------------------------
`default_nettype none

module spindle_rpm_tracker_top #(
  parameter int unsigned WINDOW_DEPTH = spt_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned PERIOD_WIDTH = spt_pkg::PERIOD_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_index_i,
  input  wire logic [spt_pkg::CFG_W-1:0]         cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              spindle_event_i,
  input  wire logic [spt_pkg::PORT_PERIOD_W-1:0] period_clocks_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [1:0]                        phase_o,
  output logic      [spt_pkg::AVG_W-1:0]         average_period_o,
  output logic      [spt_pkg::PORT_PERIOD_W-1:0] latest_period_o,
  output logic      [spt_pkg::RPM_W-1:0]         spindle_rpm_o
);

  import spt_pkg::*;

  spt_cfg_t    cfg;
  spt_cmd_t    cmd;
  spt_status_t status;

  always_comb begin
    cfg.we    = cfg_we_i;
    cfg.index = spt_cfg_idx_e'(cfg_index_i);
    cfg.data  = cfg_data_i;
  end

  spt_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .spindle_event_i (spindle_event_i),
    .in_stall_o      (in_stall_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  spt_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .PERIOD_WIDTH (PERIOD_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .status_o         (status),
    .period_clocks_i  (period_clocks_i),
    .phase_o          (phase_o),
    .average_period_o (average_period_o),
    .latest_period_o  (latest_period_o),
    .spindle_rpm_o    (spindle_rpm_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/spt_div.sv =====
// ---------------------------------------------------------------------------
// spt_div: radix-2 restoring divider
// One quotient bit per cycle; done pulses when quot_o is valid.
// ---------------------------------------------------------------------------
`default_nettype none

module spt_div #(
  parameter int unsigned NUM_W = 22,
  parameter int unsigned DEN_W = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [NUM_W-1:0] quot_o,
  output logic                  done_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    shifted = {rem_q, num_q[NUM_W-1]};
    diff    = shifted - {1'b0, den_q};
    ge      = shifted >= {1'b0, den_q};
    rem_d   = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(NUM_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  assign quot_o = num_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== hw/rtl/spt_datapath.sv =====
// ---------------------------------------------------------------------------
// spt_datapath: period window, running sum, divider and output word
// Window memory, sum and slot, average and rpm registers, rate register.
// The average is the sum shifted down by log2 of the window depth, so the
// user must keep the depth a power of two; the block does not enforce it.
// ---------------------------------------------------------------------------
`default_nettype none

module spt_datapath #(
  parameter int unsigned WINDOW_DEPTH = 16,
  parameter int unsigned PERIOD_WIDTH = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire spt_pkg::spt_cfg_t                  cfg_i,
  input  wire spt_pkg::spt_cmd_t                  cmd_i,
  output spt_pkg::spt_status_t                    status_o,
  input  wire logic [spt_pkg::PORT_PERIOD_W-1:0]  period_clocks_i,
  output logic      [1:0]                         phase_o,
  output logic      [spt_pkg::AVG_W-1:0]          average_period_o,
  output logic      [spt_pkg::PORT_PERIOD_W-1:0]  latest_period_o,
  output logic      [spt_pkg::RPM_W-1:0]          spindle_rpm_o
);

  import spt_pkg::*;

  localparam int unsigned PW    = (PERIOD_WIDTH < PORT_PERIOD_W) ? PERIOD_WIDTH
                                                                 : PORT_PERIOD_W;
  localparam int unsigned AW    = $clog2(WINDOW_DEPTH);
  localparam int unsigned SUM_W = PW + AW;
  localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_DEPTH - 1);

  logic [PW-1:0]         mem_q [WINDOW_DEPTH];
  logic [CFG_W-1:0]      rate_q;
  logic [PW-1:0]         in_period;
  logic [PW-1:0]         period_q;
  logic [PW-1:0]         old_q;
  logic [AW-1:0]         fill_addr_q;
  logic [AW-1:0]         slot_q;
  logic [SUM_W-1:0]      sum_q;
  logic [PW-1:0]         sum_avg;
  logic [PW-1:0]         avg_q;
  logic [PW-1:0]         latest_q;
  logic [RPM_W-1:0]      rpm_q;
  logic [1:0]            out_phase_q;
  logic [AVG_W-1:0]      out_avg_q;
  logic [PORT_PERIOD_W-1:0] out_latest_q;
  logic [RPM_W-1:0]      out_rpm_q;
  logic [RATE_NUM_W-1:0] rate_num;
  logic [RATE_NUM_W-1:0] quot;
  logic                  div_done;
  logic [RPM_W-1:0]      rpm_sat;

  assign in_period = period_clocks_i[PW-1:0];
  assign sum_avg   = sum_q[SUM_W-1:AW];
  assign rate_num  = RATE_NUM_W'(rate_q) * RATE_NUM_W'(SEC_PER_MIN);
  assign rpm_sat   = (quot > RATE_NUM_W'(RPM_MAX)) ? RPM_MAX : quot[RPM_W-1:0];

  spt_div #(
    .NUM_W (RATE_NUM_W),
    .DEN_W (PW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (rate_num),
    .den_i   (avg_q),
    .quot_o  (quot),
    .done_o  (div_done)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_wr) begin
      mem_q[fill_addr_q] <= period_q;
    end else if (cmd_i.upd) begin
      mem_q[slot_q] <= period_q;
    end
    if (cmd_i.rd_old) begin
      old_q <= mem_q[slot_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      period_q <= in_period;
    end
    if (cmd_i.out_load) begin
      out_phase_q  <= cmd_i.phase;
      out_avg_q    <= AVG_W'(avg_q);
      out_latest_q <= PORT_PERIOD_W'(latest_q);
      out_rpm_q    <= rpm_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= RATE_RESET;
      fill_addr_q <= '0;
      slot_q      <= '0;
      sum_q       <= '0;
      avg_q       <= '0;
      latest_q    <= '0;
      rpm_q       <= '0;
    end else begin
      if (cfg_i.we && cfg_i.index == CFG_PULSE_RATE) begin
        rate_q <= cfg_i.data;
      end
      if (cmd_i.fill_clr) begin
        sum_q       <= '0;
        fill_addr_q <= '0;
        slot_q      <= '0;
      end else if (cmd_i.fill_wr) begin
        sum_q       <= sum_q + SUM_W'(period_q);
        fill_addr_q <= fill_addr_q + 1'b1;
      end else if (cmd_i.upd) begin
        sum_q  <= sum_q - SUM_W'(old_q) + SUM_W'(period_q);
        slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
      end
      if (cmd_i.set_latest) begin
        latest_q <= in_period;
      end
      if (cmd_i.avg_load) begin
        avg_q <= sum_avg;
      end
      if (cmd_i.rpm_load) begin
        rpm_q <= rpm_sat;
      end else if (cmd_i.rpm_clr) begin
        rpm_q <= '0;
      end
      if (cmd_i.out_clr) begin
        avg_q    <= '0;
        latest_q <= '0;
        rpm_q    <= '0;
      end
    end
  end

  always_comb begin
    status_o.period_zero = (in_period == '0);
    status_o.fill_last   = (fill_addr_q == LAST_SLOT);
    status_o.div_done    = div_done;
    status_o.avg_zero    = (sum_avg == '0);
  end

  assign phase_o          = out_phase_q;
  assign average_period_o = out_avg_q;
  assign latest_period_o  = out_latest_q;
  assign spindle_rpm_o    = out_rpm_q;

endmodule

`default_nettype wire

// ===== hw/rtl/spt_ctrl.sv =====
// ---------------------------------------------------------------------------
// spt_ctrl: item sequencer and phase tracking
// Phase, held event, idle counter and timeout; issues datapath commands.
// ---------------------------------------------------------------------------
`default_nettype none

module spt_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire spt_pkg::spt_cfg_t    cfg_i,
  input  wire logic                 in_valid_i,
  input  wire logic                 spindle_event_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire spt_pkg::spt_status_t status_i,
  output spt_pkg::spt_cmd_t         cmd_o
);

  import spt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_UPD,
    S_AVG,
    S_RPM_GO,
    S_RPM,
    S_EMIT
  } state_e;

  state_e           state_q, state_d;
  spt_phase_e       phase_q, phase_d;
  logic             held_q, held_d;
  logic             to_q, to_d;
  logic             out_valid_q, out_valid_d;
  logic [IDLE_W-1:0] idle_q, idle_d;
  logic [CFG_W-1:0] timeout_q, timeout_d;
  logic [IDLE_W-1:0] idle_nx;
  logic             timeout_hit;
  logic             accept;

  assign accept = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    held_d      = held_q;
    to_d        = to_q;
    idle_d      = idle_q;
    timeout_d   = timeout_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.phase = phase_q;

    if (spindle_event_i) begin
      idle_nx = '0;
    end else begin
      idle_nx = (idle_q == IDLE_MAX) ? idle_q : idle_q + 1'b1;
    end
    timeout_hit = (idle_nx >= timeout_q);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cfg_i.we && cfg_i.index == CFG_TIMEOUT) begin
      timeout_d = cfg_i.data;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EMIT;
          case (phase_q)
            PH_ZERO: begin
              if (spindle_event_i || held_q) begin
                held_d  = 1'b0;
                idle_d  = '0;
                phase_d = PH_STARTING;
              end
            end
            PH_STARTING, PH_STEADY: begin
              idle_d = idle_nx;
              to_d   = timeout_hit;
              if (spindle_event_i) begin
                cmd_o.set_latest = 1'b1;
                if (phase_q == PH_STARTING) begin
                  if (!status_i.period_zero) begin
                    cmd_o.fill_clr = 1'b1;
                    state_d        = S_FILL;
                  end else begin
                    cmd_o.rpm_clr = 1'b1;
                    phase_d       = PH_SLOWING;
                  end
                end else begin
                  cmd_o.rd_old = 1'b1;
                  state_d      = S_UPD;
                end
              end else if (timeout_hit) begin
                phase_d = PH_SLOWING;
              end
            end
            default: begin
              cmd_o.out_clr = 1'b1;
              if (spindle_event_i) begin
                held_d = 1'b1;
              end
              phase_d = PH_ZERO;
            end
          endcase
        end
      end
      S_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (status_i.fill_last) begin
          state_d = S_AVG;
        end
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_AVG;
      end
      S_AVG: begin
        cmd_o.avg_load = 1'b1;
        if (status_i.avg_zero) begin
          cmd_o.rpm_clr = 1'b1;
          phase_d       = PH_SLOWING;
          state_d       = S_EMIT;
        end else begin
          state_d = S_RPM_GO;
        end
      end
      S_RPM_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_RPM;
      end
      S_RPM: begin
        if (status_i.div_done) begin
          cmd_o.rpm_load = 1'b1;
          phase_d        = to_q ? PH_SLOWING : PH_STEADY;
          state_d        = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_ZERO;
      held_q      <= 1'b0;
      to_q        <= 1'b0;
      out_valid_q <= 1'b0;
      idle_q      <= '0;
      timeout_q   <= TIMEOUT_RESET;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      held_q      <= held_d;
      to_q        <= to_d;
      out_valid_q <= out_valid_d;
      idle_q      <= idle_d;
      timeout_q   <= timeout_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_held_only_in_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q |-> phase_q == PH_ZERO)
    else $error("held event outside zero phase");

  a_slowing_to_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && phase_q == PH_SLOWING |=> phase_q == PH_ZERO)
    else $error("slowing item did not return to zero");

  a_zero_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && phase_q == PH_ZERO && !spindle_event_i && !held_q |=> phase_q == PH_ZERO)
    else $error("zero phase left without event");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT && !(out_valid_q && out_stall_i) |=> out_valid_q && state_q == S_IDLE)
    else $error("result word not loaded");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the spindle rpm tracker
// Walks a directed table of poll words and register writes, then runs
// randomized segments under varied rate and timeout settings. Each accepted
// word is fed to a behavioral meter model; every reading is compared field
// by field against the model or against the typed table entry.
// ---------------------------------------------------------------------------

module tb_top;
  import spt_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int WDOG_LIMIT  = 5000;
  localparam int MAX_REPORTS = 10;
  localparam int SEGMENTS    = 8;
  localparam int SEG_WORDS   = 230;
  localparam int DIR_ROWS    = 30;
  localparam int SLOT_W      = $clog2(WINDOW_DEPTH_DEF);

  typedef struct packed {
    spt_phase_e          phase;
    logic [AVG_W-1:0]    avg;
    logic [AVG_W-1:0]    latest;
    logic [RPM_W-1:0]    rpm;
  } reading_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    spt_cfg_idx_e idx;
    logic         ev;
    logic [15:0]  val;
    logic         typed;
    reading_t     want;
  } stim_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic                     cfg_index_i;
  logic [CFG_W-1:0]         cfg_data_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     spindle_event_i;
  logic [PORT_PERIOD_W-1:0] period_clocks_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [1:0]               phase_o;
  logic [AVG_W-1:0]         average_period_o;
  logic [PORT_PERIOD_W-1:0] latest_period_o;
  logic [RPM_W-1:0]         spindle_rpm_o;

  // meter model state
  spt_phase_e        m_phase;
  logic [15:0]       m_window [WINDOW_DEPTH_DEF];
  logic [19:0]       m_sum;
  logic [SLOT_W-1:0] m_slot;
  logic [15:0]       m_idle;
  logic [15:0]       m_avg;
  logic [15:0]       m_latest;
  logic [14:0]       m_rpm;
  logic              m_held;
  logic [15:0]       m_rate;
  logic [15:0]       m_timeout;

  reading_t reading_q [$];
  int       mismatches    = 0;
  int       readings_seen = 0;
  int       quiet         = 0;
  logic     cur_typed;
  reading_t cur_want;

  spindle_rpm_tracker_top dut (.*);

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic [14:0] rpm_of_avg(logic [15:0] a);
    logic [31:0] q;
    if (a == '0) return '0;
    q = (32'(m_rate) * SEC_PER_MIN) / 32'(a);
    return (q > 32'(RPM_MAX)) ? RPM_MAX : q[14:0];
  endfunction

  function automatic reading_t meter_step(logic ev, logic [15:0] p);
    case (m_phase)
      PH_ZERO: begin
        if (ev || m_held) begin
          m_held  = 1'b0;
          m_idle  = '0;
          m_phase = PH_STARTING;
        end
      end
      PH_STARTING, PH_STEADY: begin
        if (ev) begin
          m_latest = p;
          if (m_phase == PH_STARTING) begin
            if (p != '0) begin
              foreach (m_window[i]) m_window[i] = p;
              m_sum   = 20'(32'(p) * WINDOW_DEPTH_DEF);
              m_slot  = '0;
              m_avg   = 16'(m_sum / WINDOW_DEPTH_DEF);
              m_rpm   = rpm_of_avg(m_avg);
              m_phase = PH_STEADY;
            end else begin
              m_rpm   = '0;
              m_phase = PH_SLOWING;
            end
          end else begin
            m_sum = m_sum - 20'(m_window[m_slot]) + 20'(p);
            m_window[m_slot] = p;
            m_slot = m_slot + 1'b1;
            m_avg  = 16'(m_sum / WINDOW_DEPTH_DEF);
            if (m_avg != '0) begin
              m_rpm = rpm_of_avg(m_avg);
            end else begin
              m_rpm   = '0;
              m_phase = PH_SLOWING;
            end
          end
          m_idle = '0;
        end else if (m_idle != IDLE_MAX) begin
          m_idle = m_idle + 1'b1;
        end
        if (m_idle >= m_timeout) m_phase = PH_SLOWING;
      end
      default: begin
        m_avg    = '0;
        m_rpm    = '0;
        m_latest = '0;
        if (ev) m_held = 1'b1;
        m_phase  = PH_ZERO;
      end
    endcase
    return '{m_phase, m_avg, m_latest, m_rpm};
  endfunction

  function automatic stim_row_t row_word(logic ev, logic [15:0] p);
    return '{ROW_WORD, CFG_PULSE_RATE, ev, p, 1'b0, '0};
  endfunction

  function automatic stim_row_t row_typed(logic ev, logic [15:0] p, spt_phase_e ph,
                                          logic [15:0] a, logic [15:0] l, logic [14:0] r);
    return '{ROW_WORD, CFG_PULSE_RATE, ev, p, 1'b1, '{ph, a, l, r}};
  endfunction

  function automatic stim_row_t row_cfg(spt_cfg_idx_e idx, logic [15:0] v);
    return '{ROW_CFG, idx, 1'b0, v, 1'b0, '0};
  endfunction

  task automatic send_word(logic ev, logic [15:0] p, logic typed, reading_t want);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (r < 50) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 15);
    else gap = $urandom_range(30, 150);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    spindle_event_i <= ev;
    period_clocks_i <= p;
    cur_typed = typed;
    cur_want  = want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // register writes only once all readings are back
  task automatic write_reg(spt_cfg_idx_e idx, logic [15:0] v);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (reading_q.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // reading sink: random stalls plus a long hold-off to back up the input
  initial begin
    int   r;
    int   hold_left;
    int   run_left;
    int   next_hold;
    logic stall_v;
    hold_left   = 0;
    run_left    = 0;
    next_hold   = 100;
    stall_v     = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && readings_seen >= next_hold) begin
        hold_left = 400;
        next_hold += 900;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_v = 1'b1;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          stall_v  = 1'b0;
          run_left = $urandom_range(0, 7);
        end else if (r < 85) begin
          stall_v  = 1'b1;
          run_left = $urandom_range(0, 3);
        end else if (r < 95) begin
          stall_v  = 1'b1;
          run_left = $urandom_range(10, 60);
        end else begin
          stall_v  = 1'b0;
          run_left = $urandom_range(50, 200);
        end
      end
      out_stall_i <= stall_v;
    end
  end

  always @(posedge clk_i) begin
    reading_t got;
    reading_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{spt_phase_e'(phase_o), average_period_o, latest_period_o, spindle_rpm_o};
        readings_seen++;
        if (reading_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected reading: phase %0d avg %0d latest %0d rpm %0d",
                     $time, got.phase, got.avg, got.latest, got.rpm);
        end else begin
          want = reading_q.pop_front();
          if (got.phase !== want.phase || got.avg !== want.avg ||
              got.latest !== want.latest || got.rpm !== want.rpm) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: reading mismatch: exp phase %0d avg %0d latest %0d rpm %0d",
                       $time, want.phase, want.avg, want.latest, want.rpm,
                       " / got phase %0d avg %0d latest %0d rpm %0d",
                       got.phase, got.avg, got.latest, got.rpm);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        want = meter_step(spindle_event_i, period_clocks_i);
        reading_q.push_back(cur_typed ? cur_want : want);
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_PULSE_RATE) m_rate = cfg_data_i;
        else m_timeout = cfg_data_i;
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet = quiet + 1;
        if (quiet >= WDOG_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    stim_row_t   dir_tab [DIR_ROWS];
    int          base;
    int          span;
    int          v;
    int          r;
    int          len;
    int          n;
    logic [15:0] tmo;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = CFG_PULSE_RATE;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    spindle_event_i = 1'b0;
    period_clocks_i = '0;
    cur_typed       = 1'b0;
    cur_want        = '0;

    m_phase   = PH_ZERO;
    foreach (m_window[i]) m_window[i] = '0;
    m_sum     = '0;
    m_slot    = '0;
    m_idle    = '0;
    m_avg     = '0;
    m_latest  = '0;
    m_rpm     = '0;
    m_held    = 1'b0;
    m_rate    = RATE_RESET;
    m_timeout = TIMEOUT_RESET;

    dir_tab = '{
      row_typed(1'b0, 16'h0000, PH_ZERO,     16'd0, 16'd0, 15'd0),
      row_typed(1'b1, 16'hffff, PH_STARTING, 16'd0, 16'd0, 15'd0),
      row_typed(1'b1, 16'h0000, PH_SLOWING,  16'd0, 16'd0, 15'd0),  // zero first fill
      row_typed(1'b1, 16'h1234, PH_ZERO,     16'd0, 16'd0, 15'd0),  // held event
      row_typed(1'b0, 16'h0000, PH_STARTING, 16'd0, 16'd0, 15'd0),
      row_typed(1'b1, 16'h0001, PH_STEADY,   16'd1, 16'd1, RPM_MAX),
      row_typed(1'b1, 16'h0000, PH_SLOWING,  16'd0, 16'd0, 15'd0),  // average drops to 0
      row_typed(1'b0, 16'hffff, PH_ZERO,     16'd0, 16'd0, 15'd0),
      row_typed(1'b1, 16'h0000, PH_STARTING, 16'd0, 16'd0, 15'd0),
      row_typed(1'b1, 16'hffff, PH_STEADY,   16'hffff, 16'hffff, 15'd18),
      row_word(1'b1, 16'h0000),
      row_word(1'b0, 16'hffff),
      row_word(1'b1, 16'h8000),
      row_word(1'b1, 16'h5555),
      row_word(1'b1, 16'haaaa),
      row_cfg(CFG_TIMEOUT, 16'd1),
      row_word(1'b0, 16'h0000),
      row_typed(1'b0, 16'h0000, PH_ZERO,     16'd0, 16'd0, 15'd0),
      row_cfg(CFG_PULSE_RATE, 16'd0),
      row_typed(1'b1, 16'd100,  PH_STARTING, 16'd0, 16'd0, 15'd0),
      row_typed(1'b1, 16'd100,  PH_STEADY,   16'd100, 16'd100, 15'd0),
      row_word(1'b1, 16'd7),
      row_cfg(CFG_TIMEOUT, 16'd0),
      row_word(1'b1, 16'd200),
      row_typed(1'b1, 16'd0,    PH_ZERO,     16'd0, 16'd0, 15'd0),
      row_typed(1'b0, 16'd0,    PH_STARTING, 16'd0, 16'd0, 15'd0),
      row_cfg(CFG_PULSE_RATE, 16'hffff),
      row_cfg(CFG_TIMEOUT, 16'hffff),
      row_typed(1'b1, 16'd1,    PH_STEADY,   16'd1, 16'd1, RPM_MAX),
      row_word(1'b1, 16'hffff)
    };

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG)
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      else
        send_word(dir_tab[i].ev, dir_tab[i].val, dir_tab[i].typed, dir_tab[i].want);
    end

    // random segments: mostly jittered periods around a base, plus noise,
    // zero periods and idle runs long enough to trip the timeout
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case ($urandom_range(0, 4))
        0: v = 1;
        1: v = 65535;
        default: v = $urandom_range(1, 65535);
      endcase
      write_reg(CFG_PULSE_RATE, v[15:0]);
      case ($urandom_range(0, 5))
        0: tmo = 16'hffff;
        1: tmo = 16'd1;
        default: tmo = 16'($urandom_range(2, 40));
      endcase
      write_reg(CFG_TIMEOUT, tmo);
      base = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 65535);
      span = base / 16 + 1;
      n = 0;
      while (n < SEG_WORDS) begin
        r = $urandom_range(0, 99);
        if (r < 4 && tmo <= 16'd64) begin
          len = $urandom_range(tmo, tmo + 2);
          repeat (len) send_word(1'b0, 16'($urandom), 1'b0, '0);
          n += len;
        end else begin
          if (r < 64) begin
            v = base + $urandom_range(0, 2 * span) - span;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            send_word(1'b1, v[15:0], 1'b0, '0);
          end else if (r < 78) begin
            send_word(1'b1, 16'($urandom), 1'b0, '0);
          end else if (r < 81) begin
            send_word(1'b1, 16'd0, 1'b0, '0);
          end else begin
            send_word(1'b0, 16'($urandom), 1'b0, '0);
          end
          n++;
        end
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (reading_q.size() != 0) @(negedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && reading_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
